// ===== hdl/acs_pkg.sv =====
`timescale 1ns / 1ps

package acs_pkg;

  // fixed field widths
  localparam int unsigned WC_W      = 5;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  // operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ITER   = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_OWN_RD,
    S_OWN_CHK,
    S_SCAN,
    S_DIV,
    S_DIV_FIN,
    S_PART,
    S_WB,
    S_RESP
  } state_e;

endpackage

// ===== hdl/affinity_chunk_scheduler_core.sv =====
`timescale 1ns / 1ps
// start: shared divider, then one block write per cycle
// own-block request: own read and check, divide, write back; steal request: a scan of all blocks before the divide
// the block table has one read and one write port, so a steal scan reads one block per cycle
// one transaction in flight: in_ready_o is high only in the idle state
// async active-low reset: all blocks read empty, worker_count = 1, total_iterations = 0
module affinity_chunk_scheduler_core
  import acs_pkg::*;
#(
  parameter int unsigned MAX_WORKERS = 16,
  parameter int unsigned ITER_WIDTH  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [ID_W-1:0]       worker_id_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  granted_o,
  output logic [ID_W-1:0]       source_worker_o,
  output logic [ITER_WIDTH-1:0] chunk_lo_o,
  output logic [ITER_WIDTH-1:0] chunk_hi_o
);

  localparam int unsigned W   = ITER_WIDTH;
  localparam int unsigned IW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned CW  = $clog2(MAX_WORKERS + 1);
  localparam int unsigned DCW = $clog2(W + 1);

  // configuration registers
  logic [WC_W-1:0] wc_q;
  logic [W-1:0]    total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q    <= WC_W'(1);
      total_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WORKER_COUNT: wc_q <= cfg_wdata_i[WC_W-1:0];
        CFG_TOTAL_ITER:   total_q <= W'(cfg_wdata_i);
        default:          ;
      endcase
    end
  end

  // effective worker count: zero counts as one, saturate at MAX_WORKERS
  logic [WC_W-1:0] n_eff;
  always_comb begin
    if (wc_q == '0) begin
      n_eff = WC_W'(1);
    end else if (32'(wc_q) > MAX_WORKERS) begin
      n_eff = WC_W'(MAX_WORKERS);
    end else begin
      n_eff = wc_q;
    end
  end

  // state and datapath registers
  state_e            state_q, state_d;
  logic              op_q, op_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic              gnt_q, gnt_d;
  logic [IW-1:0]     src_q, src_d;
  logic [W-1:0]      best_q, best_d;
  logic [W-1:0]      lo_q, lo_d;
  logic [W-1:0]      hi_q, hi_d;
  logic [W-1:0]      res_q, res_d;
  logic [W-1:0]      acc_q, acc_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [WC_W-1:0]   div_rem_q, div_rem_d;
  logic [W-1:0]      div_quo_q, div_quo_d;
  logic [DCW-1:0]    div_cnt_q, div_cnt_d;

  // block table: {high, low} per worker, valid bits make unwritten entries read empty
  logic [2*W-1:0]         mem [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] vld_q;
  logic [2*W-1:0]         rd_data_q;
  logic                   rd_vld_q;
  logic [IW-1:0]          rd_idx_q;
  logic [IW-1:0]          raddr;
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [2*W-1:0]         mem_wdata;

  // output register
  logic            out_valid_q;
  logic            out_gnt_q;
  logic [ID_W-1:0] out_src_q;
  logic [W-1:0]    out_lo_q;
  logic [W-1:0]    out_hi_q;
  logic            out_free;
  logic            in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // entry read back from the table
  logic [W-1:0] ent_lo, ent_hi, ent_left;
  always_comb begin
    ent_lo   = rd_vld_q ? rd_data_q[W-1:0] : '0;
    ent_hi   = rd_vld_q ? rd_data_q[2*W-1:W] : '0;
    ent_left = (ent_hi > ent_lo) ? (ent_hi - ent_lo) : '0;
  end

  logic own_ok;
  assign own_ok = (32'(id_q) < MAX_WORKERS);

  // shared divider step: one quotient bit per cycle
  logic [WC_W:0]   div_trial;
  logic            div_bit;
  logic [W-1:0]    div_res;
  always_comb begin
    div_trial = {div_rem_q, div_quo_q[W-1]};
    div_bit   = (div_trial >= {1'b0, n_eff});
    div_res   = div_quo_q + W'(div_rem_q != '0);
  end

  // partition block end, clamped to total
  logic [W:0]   part_sum;
  logic [W-1:0] part_hi;
  logic         part_last;
  logic         part_use;
  always_comb begin
    part_sum  = {1'b0, acc_q} + {1'b0, res_q};
    part_hi   = (part_sum > {1'b0, total_q}) ? total_q : part_sum[W-1:0];
    part_last = (cnt_q == CW'(MAX_WORKERS - 1));
    part_use  = (32'(cnt_q) < 32'(n_eff));
  end

  logic scan_end;
  assign scan_end = (cnt_q == CW'(MAX_WORKERS));

  // datapath and table control
  always_comb begin
    op_d      = op_q;
    id_d      = id_q;
    gnt_d     = gnt_q;
    src_d     = src_q;
    best_d    = best_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    res_d     = res_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_cnt_d = div_cnt_q;
    raddr     = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d      = op_i;
          id_d      = worker_id_i;
          gnt_d     = 1'b0;
          src_d     = '0;
          best_d    = '0;
          lo_d      = '0;
          res_d     = '0;
          div_rem_d = '0;
          div_quo_d = total_q;
          div_cnt_d = '0;
        end
      end
      S_OWN_RD: begin
        raddr = IW'(id_q);
      end
      S_OWN_CHK: begin
        cnt_d  = '0;
        best_d = '0;
        if (own_ok && ent_left != '0) begin
          gnt_d     = 1'b1;
          src_d     = rd_idx_q;
          best_d    = ent_left;
          lo_d      = ent_lo;
          hi_d      = ent_hi;
          div_rem_d = '0;
          div_quo_d = ent_left;
          div_cnt_d = '0;
        end
      end
      S_SCAN: begin
        raddr = cnt_q[IW-1:0];
        cnt_d = cnt_q + CW'(1);
        // data from the previous cycle's read, lowest index wins a tie
        if (cnt_q != '0 && ent_left > best_q) begin
          best_d = ent_left;
          src_d  = rd_idx_q;
          lo_d   = ent_lo;
          hi_d   = ent_hi;
        end
        if (scan_end && best_d != '0) begin
          gnt_d     = 1'b1;
          div_rem_d = '0;
          div_quo_d = best_d;
          div_cnt_d = '0;
        end
      end
      S_DIV: begin
        div_rem_d = div_bit ? WC_W'(div_trial - {1'b0, n_eff}) : div_trial[WC_W-1:0];
        div_quo_d = {div_quo_q[W-2:0], div_bit};
        div_cnt_d = div_cnt_q + DCW'(1);
      end
      S_DIV_FIN: begin
        res_d = div_res;
        cnt_d = '0;
        acc_d = '0;
      end
      S_PART: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IW-1:0];
        mem_wdata = part_use ? {part_hi, acc_q} : '0;
        acc_d     = part_hi;
        cnt_d     = cnt_q + CW'(1);
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = src_q;
        mem_wdata = {hi_q, lo_q + res_q};
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (op_i == OP_START) ? S_DIV : S_OWN_RD;
        end
      end
      S_OWN_RD:  state_d = S_OWN_CHK;
      S_OWN_CHK: state_d = (own_ok && ent_left != '0) ? S_DIV : S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_d = (best_d != '0) ? S_DIV : S_RESP;
        end
      end
      S_DIV: begin
        if (div_cnt_q == DCW'(W - 1)) begin
          state_d = S_DIV_FIN;
        end
      end
      S_DIV_FIN: state_d = (op_q == OP_START) ? S_PART : S_WB;
      S_PART: begin
        if (part_last) begin
          state_d = S_RESP;
        end
      end
      S_WB: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    gnt_q     <= gnt_d;
    src_q     <= src_d;
    best_q    <= best_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    res_q     <= res_d;
    acc_q     <= acc_d;
    cnt_q     <= cnt_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_cnt_q <= div_cnt_d;
  end

  // block table write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[raddr];
    rd_idx_q  <= raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr];
    end
  end

  // result transaction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP && out_free) begin
      out_gnt_q <= gnt_q;
      out_src_q <= gnt_q ? ID_W'(src_q) : '0;
      out_lo_q  <= gnt_q ? lo_q : '0;
      out_hi_q  <= gnt_q ? (lo_q + res_q) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = out_gnt_q;
  assign source_worker_o = out_src_q;
  assign chunk_lo_o      = out_lo_q;
  assign chunk_hi_o      = out_hi_q;

`ifndef NO_ASSERTIONS
  // a granted chunk is never empty
  a_chunk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_o) |-> (chunk_hi_o != chunk_lo_o))
    else $error("granted chunk is empty");

  // a result without a grant carries all-zero fields
  a_nogrant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |->
      (source_worker_o == '0 && chunk_lo_o == '0 && chunk_hi_o == '0))
    else $error("no-grant result has nonzero fields");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted a transaction while busy");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import acs_pkg::*;

  localparam int unsigned MAX_WORKERS   = 16;
  localparam int unsigned ITER_WIDTH    = 16;
  // longest path through the block (steal request) plus some margin
  localparam int unsigned SETTLE_CYCLES = ITER_WIDTH + MAX_WORKERS + 12;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RANDOM_ITEMS  = 1800;
  localparam int unsigned HOLD_CYCLES   = 240;
  localparam int unsigned PRINT_CAP     = 40;

  typedef struct packed {
    logic                  granted;
    logic [ID_W-1:0]       source;
    logic [ITER_WIDTH-1:0] lo;
    logic [ITER_WIDTH-1:0] hi;
  } chunk_grant_t;

  // tracks block ranges and the grants the scheduler owes
  class grant_tracker;
    logic [WC_W-1:0]       worker_count;
    logic [ITER_WIDTH-1:0] total_iter;
    logic [ITER_WIDTH-1:0] blk_lo [MAX_WORKERS];
    logic [ITER_WIDTH-1:0] blk_hi [MAX_WORKERS];
    chunk_grant_t          owed_grants [$];
    int unsigned           errors;

    function new();
      worker_count = WC_W'(1);
      total_iter   = '0;
      errors       = 0;
      for (int w = 0; w < MAX_WORKERS; w++) begin
        blk_lo[w] = '0;
        blk_hi[w] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_WORKER_COUNT) begin
        worker_count = data[WC_W-1:0];
      end else begin
        total_iter = data[ITER_WIDTH-1:0];
      end
    endfunction

    // zero counts as one, large counts saturate
    function int unsigned live_workers();
      int unsigned n;
      n = worker_count;
      if (n == 0) n = 1;
      if (n > MAX_WORKERS) n = MAX_WORKERS;
      return n;
    endfunction

    function int unsigned left_in(int unsigned w);
      return (blk_hi[w] > blk_lo[w]) ? int'(blk_hi[w] - blk_lo[w]) : 0;
    endfunction

    // equal contiguous blocks, clamped to the total, unused blocks emptied
    function void partition();
      int unsigned n, tot, ipt, lo, hi;
      n   = live_workers();
      tot = total_iter;
      ipt = (tot + n - 1) / n;
      for (int unsigned w = 0; w < MAX_WORKERS; w++) begin
        if (w < n) begin
          lo = w * ipt;
          hi = lo + ipt;
          if (lo > tot) lo = tot;
          if (hi > tot) hi = tot;
          blk_lo[w] = lo[ITER_WIDTH-1:0];
          blk_hi[w] = hi[ITER_WIDTH-1:0];
        end else begin
          blk_lo[w] = '0;
          blk_hi[w] = '0;
        end
      end
    endfunction

    function chunk_grant_t predict_grant(logic op, logic [ID_W-1:0] id);
      chunk_grant_t res;
      int unsigned  best, src, rem, n, lo, hi;
      bit           found;
      res   = '0;
      found = 1'b0;
      src   = 0;
      if (op == OP_START) begin
        partition();
        return res;
      end
      // own block first, otherwise steal from the fullest (lowest index on a tie)
      if (left_in(id) > 0) begin
        found = 1'b1;
        src   = id;
      end else begin
        best = 0;
        for (int unsigned w = 0; w < MAX_WORKERS; w++) begin
          if (left_in(w) > best) begin
            best  = left_in(w);
            src   = w;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        n   = live_workers();
        rem = left_in(src);
        lo  = blk_lo[src];
        hi  = lo + (rem + n - 1) / n;
        blk_lo[src] = hi[ITER_WIDTH-1:0];
        res.granted = 1'b1;
        res.source  = src[ID_W-1:0];
        res.lo      = lo[ITER_WIDTH-1:0];
        res.hi      = hi[ITER_WIDTH-1:0];
      end
      return res;
    endfunction

    function void note_request(logic op, logic [ID_W-1:0] id);
      owed_grants.push_back(predict_grant(op, id));
    endfunction

    function int unsigned pending();
      return owed_grants.size();
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      if (errors < PRINT_CAP) begin
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      end
      errors++;
    endtask

    task check_result(chunk_grant_t got);
      chunk_grant_t want;
      if (owed_grants.size() == 0) begin
        report("transaction with nothing pending", 1, 0);
      end else begin
        want = owed_grants.pop_front();
        if (got.granted !== want.granted) report("granted", got.granted, want.granted);
        if (got.source !== want.source) report("source_worker", got.source, want.source);
        if (got.lo !== want.lo) report("chunk_lo", got.lo, want.lo);
        if (got.hi !== want.hi) report("chunk_hi", got.hi, want.hi);
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DAT_W-1:0]  cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  op_i;
  logic [ID_W-1:0]       worker_id_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  granted_o;
  logic [ID_W-1:0]       source_worker_o;
  logic [ITER_WIDTH-1:0] chunk_lo_o;
  logic [ITER_WIDTH-1:0] chunk_hi_o;

  grant_tracker tracker = new();
  int unsigned  items_sent = 0;
  int unsigned  cycles = 0;
  logic         calm;

  // a stretch of the run where neither side idles
  assign calm = (items_sent >= 700) && (items_sent < 1000);

  affinity_chunk_scheduler_core #(
    .MAX_WORKERS(MAX_WORKERS),
    .ITER_WIDTH (ITER_WIDTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .worker_id_i    (worker_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .granted_o      (granted_o),
    .source_worker_o(source_worker_o),
    .chunk_lo_o     (chunk_lo_o),
    .chunk_hi_o     (chunk_hi_o)
  );

  always #6 clk_i = ~clk_i;

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result({granted_o, source_worker_o, chunk_lo_o, chunk_hi_o});
    end
  end

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && items_sent >= 300) begin
        held        = 1'b1;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i = calm || ($urandom_range(0, 99) >= 16);
    end
  end

  // called at a falling edge; leaves valid high after the transaction
  task automatic send_item(logic op, logic [ID_W-1:0] id);
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    op_i        = op;
    worker_id_i = id;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(op, id);
    items_sent++;
    @(negedge clk_i);
  endtask

  // drop valid, wait for every owed grant, then let the block go idle
  task automatic settle();
    in_valid_i = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // worker count write with random junk above the register width
  task automatic write_count(int unsigned wc);
    logic [CFG_DAT_W-1:0] data;
    data           = CFG_DAT_W'($urandom);
    data[WC_W-1:0] = wc[WC_W-1:0];
    write_reg(CFG_WORKER_COUNT, data);
  endtask

  function automatic int unsigned pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 0;
    if (roll < 22) return $urandom_range(17, 31);
    if (roll < 40) return $urandom_range(1, 4);
    return $urandom_range(1, 16);
  endfunction

  // one loop: new config, a start, then mostly requests from live workers
  task automatic run_loop();
    int unsigned          n_req, roll, n;
    logic [CFG_DAT_W-1:0] tot;
    settle();
    write_count(pick_count());
    roll = $urandom_range(0, 99);
    if (roll < 40) tot = CFG_DAT_W'($urandom_range(0, 64));
    else if (roll < 80) tot = CFG_DAT_W'($urandom_range(0, 1023));
    else tot = CFG_DAT_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < 75) write_reg(CFG_TOTAL_ITER, tot);
    send_item(OP_START, ID_W'($urandom_range(0, 15)));
    n_req = $urandom_range(4, 60);
    for (int unsigned i = 0; i < n_req; i++) begin
      // occasionally change the count while a loop is in flight
      if (i == n_req / 2 && $urandom_range(0, 99) < 20) begin
        settle();
        write_count(pick_count());
      end
      n    = tracker.live_workers();
      roll = $urandom_range(0, 99);
      if (roll < 4) send_item(OP_START, ID_W'($urandom_range(0, 15)));
      else if (roll < 80) send_item(OP_REQUEST, ID_W'($urandom_range(0, n - 1)));
      else send_item(OP_REQUEST, ID_W'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_WORKER_COUNT;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    op_i        = OP_START;
    worker_id_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table after reset, and a start with the reset config
    send_item(OP_REQUEST, ID_W'(0));
    send_item(OP_REQUEST, ID_W'(15));
    send_item(OP_START, ID_W'(7));
    send_item(OP_REQUEST, ID_W'(0));

    // four workers over ten iterations: own chunk, empty own block, tie, outsider
    settle();
    write_count(4);
    write_reg(CFG_TOTAL_ITER, CFG_DAT_W'(10));
    send_item(OP_START, ID_W'(0));
    send_item(OP_REQUEST, ID_W'(0));
    send_item(OP_REQUEST, ID_W'(3));
    send_item(OP_REQUEST, ID_W'(3));
    send_item(OP_REQUEST, ID_W'(12));

    // zero count acts as one worker: whole range in one chunk, then nothing
    settle();
    write_count(0);
    write_reg(CFG_TOTAL_ITER, 16'hFFFF);
    send_item(OP_START, ID_W'(15));
    send_item(OP_REQUEST, ID_W'(0));
    send_item(OP_REQUEST, ID_W'(5));

    // count beyond the maximum saturates
    settle();
    write_reg(CFG_WORKER_COUNT, 16'hFFFF);
    send_item(OP_START, ID_W'(0));
    send_item(OP_REQUEST, ID_W'(15));
    send_item(OP_REQUEST, ID_W'(0));

    // more workers than iterations: trailing blocks lie past the end
    settle();
    write_count(16);
    write_reg(CFG_TOTAL_ITER, CFG_DAT_W'(5));
    send_item(OP_START, ID_W'(0));
    send_item(OP_REQUEST, ID_W'(10));

    // count changed with a loop in flight
    settle();
    write_count(2);
    send_item(OP_REQUEST, ID_W'(1));

    // restart with fewer workers clears the upper blocks
    send_item(OP_START, ID_W'(3));
    send_item(OP_REQUEST, ID_W'(9));

    while (items_sent < RANDOM_ITEMS + 25) run_loop();

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
